[src/bfra_pkg.sv]
// Package: shared types and codes for the best-fit range allocator.
`timescale 1ns / 1ps
package bfra_pkg;

  localparam int unsigned HandleW  = 48;
  localparam int unsigned CountW   = 17;
  localparam int unsigned SlotIdxW = 17;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_FREED    = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_FULL     = 3'd5,
    ST_RESET    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    CFG_KIND     = 3'd0,
    CFG_CAPACITY = 3'd1,
    CFG_STRIDE   = 3'd2,
    CFG_CPU_BASE = 3'd3,
    CFG_GPU_BASE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [CountW-1:0]  slot_count;
    logic [HandleW-1:0] freed_handle;
    logic               freed_valid;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [HandleW-1:0] cpu_handle;
    logic [HandleW-1:0] gpu_handle;
    logic [CountW-1:0]  granted_count;
    logic [CountW-1:0]  granted_offset;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SCAN_RD,
    S_SCAN,
    S_FIND,
    S_ALLOC_END,
    S_CLEAR,
    S_MUL,
    S_ADD,
    S_OUT
  } state_e;

endpackage

[src/best_fit_range_allocator.sv]
// Top level of the best-fit range allocator: control, config and handle math.
// Usage: requests arrive on req (valid/ready) as one word of op, slot_count,
// freed_handle and freed_valid; each yields one result word on rsp.
// Allocate scans the free table one entry per cycle from a registered-read
// memory, then passes through the alloc-end, multiply and add states to the
// output register; the table write-back happens in the alloc-end state.
// Free runs a 48-bit bit-serial division by the stride, then stores the
// block in the lowest unused entry; a zero stride skips the division.
// The reset op drops all valid bits at once; zero-size allocations, ignored
// frees and unknown ops go straight to the multiply and add states.
// One item is in work at a time; req_ready_o is high in the idle state, so a
// new word can be taken in the cycle after the result word is taken.
// The result sits in an output register until taken; a stalled receiver
// holds the block in the output state without losing the word.
// Configuration words on cfg (index, data) are taken at any time and must
// be written only while idle. Reset clears table valid bits, the bump
// pointer, the age counter and loads register defaults.
`timescale 1ns / 1ps
module best_fit_range_allocator import bfra_pkg::*; #(
  parameter int unsigned FREE_TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  localparam int unsigned IdxW = (FREE_TABLE_DEPTH > 1) ? $clog2(FREE_TABLE_DEPTH) : 1;
  localparam int unsigned SW   = SlotIdxW;
  localparam int unsigned CW   = IdxW + 1;

  logic [1:0]         kind_q;
  logic [CountW-1:0]  cap_q;
  logic [8:0]         stride_q;
  logic [47:0]        cpu_base_q, gpu_base_q;

  state_e state_q, state_d;
  req_t   req_q;
  logic [31:0]   age_q;
  logic [SW-1:0] bump_q;
  logic [CW-1:0] scan_q;
  logic          best_ok_q;
  logic [IdxW-1:0] best_idx_q;
  logic [SW-1:0] best_size_q, best_start_q;
  logic [31:0]   best_dist_q;
  logic [2:0]    status_q;
  logic [CountW-1:0] off_q, cnt_q;
  logic [47:0]   step_q;
  rsp_t          rsp_q;

  logic clear, wr_en, wr_used;
  logic [IdxW-1:0] wr_addr, rd_addr, free_idx;
  logic [SW-1:0]   wr_size, wr_start, rd_size, rd_start;
  logic [31:0]     rd_age, age_gap;
  logic            rd_used, free_found, div_start, div_done;
  logic [47:0]     quot;
  logic [SW-1:0]   req_cnt;
  logic            cand, better;
  logic [CountW:0] bump_sum;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= '0; cap_q <= 17'd1024; stride_q <= 9'd32;
      cpu_base_q <= '0; gpu_base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_KIND:     kind_q     <= cfg_data_i[1:0];
        CFG_CAPACITY: cap_q      <= cfg_data_i[CountW-1:0];
        CFG_STRIDE:   stride_q   <= cfg_data_i[8:0];
        CFG_CPU_BASE: cpu_base_q <= cfg_data_i;
        CFG_GPU_BASE: gpu_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bfra_table #(.Depth(FREE_TABLE_DEPTH), .IdxW(IdxW), .SlotW(SW)) u_table (
    .clk_i, .rst_ni, .clear_i(clear), .rd_addr_i(rd_addr),
    .rd_size_o(rd_size), .rd_start_o(rd_start), .rd_age_o(rd_age), .rd_used_o(rd_used),
    .wr_en_i(wr_en), .wr_used_i(wr_used), .wr_addr_i(wr_addr), .wr_size_i(wr_size),
    .wr_start_i(wr_start), .wr_age_i(age_q),
    .free_idx_o(free_idx), .free_found_o(free_found)
  );

  bfra_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i(req_i.freed_handle - cpu_base_q), .divisor_i(stride_q),
    .done_o(div_done), .quotient_o(quot)
  );

  assign req_cnt  = SW'(req_q.slot_count);
  assign age_gap  = age_q - rd_age;
  assign cand     = rd_used && ({{(32-SW){1'b0}}, rd_size} >= 32'(req_q.slot_count));
  assign better   = !best_ok_q || (rd_size < best_size_q) ||
                    ((rd_size == best_size_q) && (age_gap > best_dist_q));
  assign bump_sum = {1'b0, CountW'(bump_q)} + {1'b0, req_q.slot_count};
  assign rd_addr  = scan_q[IdxW-1:0];

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_OUT);
  assign rsp_o       = rsp_q;
  assign div_start   = req_valid_i && req_ready_o && (op_e'(req_i.op) == OP_FREE)
                       && req_i.freed_valid && (stride_q != '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req_valid_i) begin
        case (op_e'(req_i.op))
          OP_ALLOC: state_d = (req_i.slot_count == '0) ? S_MUL : S_SCAN_RD;
          OP_FREE:  state_d = !req_i.freed_valid ? S_MUL :
                              (stride_q != '0) ? S_DIV : S_FIND;
          OP_RESET: state_d = S_CLEAR;
          default:  state_d = S_MUL;
        endcase
      end
      S_DIV:       if (div_done) state_d = S_FIND;
      S_SCAN_RD:   state_d = S_SCAN;
      S_SCAN:      if (scan_q == CW'(FREE_TABLE_DEPTH)) state_d = S_ALLOC_END;
      S_FIND:      state_d = S_MUL;
      S_ALLOC_END: state_d = S_MUL;
      S_CLEAR:     state_d = S_MUL;
      S_MUL:       state_d = S_ADD;
      S_ADD:       state_d = S_OUT;
      S_OUT:       if (rsp_ready_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    clear = (state_q == S_CLEAR);
    wr_en = 1'b0; wr_used = 1'b0; wr_addr = best_idx_q;
    wr_size = best_size_q - req_cnt; wr_start = best_start_q + req_cnt;
    if (state_q == S_ALLOC_END && best_ok_q) begin
      wr_en   = 1'b1;
      wr_used = (best_size_q > req_cnt);
    end else if (state_q == S_FIND && free_found) begin
      wr_en    = 1'b1; wr_used = 1'b1; wr_addr = free_idx;
      wr_size  = req_cnt;
      wr_start = off_q[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; age_q <= '0; bump_q <= '0;
      scan_q <= '0; best_ok_q <= 1'b0; status_q <= ST_IGNORED;
    end else begin
      state_q <= state_d;
      if (wr_en && wr_used) age_q <= age_q + 32'd1;
      case (state_q)
        S_IDLE: begin
          scan_q <= '0; best_ok_q <= 1'b0;
          case (op_e'(req_i.op))
            OP_ALLOC: status_q <= (req_i.slot_count == '0) ? ST_ZERO : ST_GRANTED;
            OP_FREE:  status_q <= req_i.freed_valid ? ST_FREED : ST_IGNORED;
            OP_RESET: status_q <= ST_RESET;
            default:  status_q <= ST_IGNORED;
          endcase
        end
        S_SCAN_RD: scan_q <= scan_q + CW'(1);
        S_SCAN: begin
          if (scan_q != CW'(FREE_TABLE_DEPTH)) scan_q <= scan_q + CW'(1);
          if (cand && better) best_ok_q <= 1'b1;
        end
        S_ALLOC_END: if (!best_ok_q) begin
          if (bump_sum <= {1'b0, cap_q}) bump_q <= bump_sum[SW-1:0];
          else status_q <= ST_NO_SPACE;
        end
        S_FIND: if (!free_found) status_q <= ST_FULL;
        S_CLEAR: begin age_q <= '0; bump_q <= '0; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) begin
      req_q <= req_i;
      off_q <= '0;
      cnt_q <= req_i.slot_count;
    end
    if (state_q == S_DIV && div_done) off_q <= CountW'(quot[SW-1:0]);
    if (state_q == S_SCAN && cand && better) begin
      best_idx_q   <= IdxW'(scan_q - CW'(1));
      best_size_q  <= rd_size;
      best_start_q <= rd_start;
      best_dist_q  <= age_gap;
    end
    if (state_q == S_ALLOC_END)
      off_q <= best_ok_q ? CountW'(best_start_q) : CountW'(bump_q);
    if (state_q == S_MUL) step_q <= 48'({31'd0, off_q} * {39'd0, stride_q});
    if (state_q == S_ADD) begin
      rsp_q.status <= status_q;
      if (status_e'(status_q) == ST_GRANTED) begin
        rsp_q.cpu_handle     <= cpu_base_q + step_q;
        rsp_q.gpu_handle     <= (kind_q == 2'd0 || kind_q == 2'd3) ? gpu_base_q + step_q : '0;
        rsp_q.granted_count  <= cnt_q;
        rsp_q.granted_offset <= off_q;
      end else begin
        rsp_q.cpu_handle     <= '0;
        rsp_q.gpu_handle     <= '0;
        rsp_q.granted_count  <= '0;
        rsp_q.granted_offset <= '0;
      end
    end
  end
endmodule

[src/bfra_divider.sv]
// Divider: restoring 48-by-9 bit division, one quotient bit per cycle.
`timescale 1ns / 1ps
module bfra_divider import bfra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [HandleW-1:0] dividend_i,
  input  logic [8:0]         divisor_i,
  output logic               done_o,
  output logic [HandleW-1:0] quotient_o
);
  logic [HandleW-1:0] quo_q, quo_d;
  logic [9:0]         rem_q, rem_d;
  logic [8:0]         dvs_q;
  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [9:0]         trial;

  always_comb begin
    trial  = {rem_q[8:0], quo_q[HandleW-1]};
    quo_d  = {quo_q[HandleW-2:0], 1'b0};
    rem_d  = trial;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 6'(HandleW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      cnt_d  = cnt_q - 6'd1;
      busy_d = (cnt_q != 6'd1);
    end else begin
      quo_d = quo_q;
      rem_d = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o     = busy_q && (cnt_q == 6'd1);
  assign quotient_o = quo_d;
endmodule

[src/bfra_table.sv]
// Free table: synchronous memory of size, start and age with valid bits.
`timescale 1ns / 1ps
module bfra_table import bfra_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6,
  parameter int unsigned SlotW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [SlotW-1:0] rd_size_o,
  output logic [SlotW-1:0] rd_start_o,
  output logic [31:0]      rd_age_o,
  output logic             rd_used_o,
  input  logic             wr_en_i,
  input  logic             wr_used_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [SlotW-1:0] wr_size_i,
  input  logic [SlotW-1:0] wr_start_i,
  input  logic [31:0]      wr_age_i,
  output logic [IdxW-1:0]  free_idx_o,
  output logic             free_found_o
);
  logic [SlotW+SlotW+32-1:0] mem [Depth];
  logic [Depth-1:0]          used_q;
  logic [SlotW+SlotW+32-1:0] rd_q;
  logic                      rd_used_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_used_i) mem[wr_addr_i] <= {wr_size_i, wr_start_i, wr_age_i};
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      rd_used_q <= used_q[rd_addr_i];
      if (clear_i) used_q <= '0;
      else if (wr_en_i) used_q[wr_addr_i] <= wr_used_i;
    end
  end

  always_comb begin
    free_idx_o   = '0;
    free_found_o = 1'b0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx_o   = IdxW'(i);
        free_found_o = 1'b1;
      end
    end
  end

  assign rd_size_o  = rd_q[SlotW+SlotW+31:SlotW+32];
  assign rd_start_o = rd_q[SlotW+31:32];
  assign rd_age_o   = rd_q[31:0];
  assign rd_used_o  = rd_used_q;
endmodule

[src/bfra_checker.sv]
// Checker: port-level properties of the allocator, bound to the top level.
`timescale 1ns / 1ps
module bfra_checker import bfra_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input rsp_t rsp_o
);
  a_no_req_while_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o) else $error("ready during pending result");
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result dropped");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != ST_GRANTED |-> rsp_o.granted_count == '0)
    else $error("count on failure");
  a_accept_not_immediate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !rsp_valid_o) else $error("result too early");
endmodule

bind best_fit_range_allocator bfra_checker u_bfra_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o
);
